@@ sv/obd_pkg.sv @@
// ----------------------------------------------------------------------------
// obd_pkg
// Shared types and constants of the object identifier text decoder.
// ----------------------------------------------------------------------------
package obd_pkg;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // word index of the absolute_oid register
  localparam logic REG_ABSOLUTE_OID = 1'b0;

  localparam int ARC_RADIX = 40;
  localparam int ARC_SPLIT = 80;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NONE = 8'h00;

  localparam int CONT_BIT = 7;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_TRUNCATED = 2'd2
  } err_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_DOT,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic shift;
  } cnv_ctl_t;

endpackage

@@ sv/obd_byte_if.sv @@
// ----------------------------------------------------------------------------
// obd_byte_if
// Request channel carrying one BER content octet of an object identifier.
// ----------------------------------------------------------------------------
interface obd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] content_byte;
  logic       final_byte;

  modport source (output valid, content_byte, final_byte, input ready);
  modport sink   (input valid, content_byte, final_byte, output ready);
endinterface

@@ sv/obd_text_if.sv @@
// ----------------------------------------------------------------------------
// obd_text_if
// Request channel carrying one character of dotted-decimal text.
// ----------------------------------------------------------------------------
interface obd_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic [1:0] error_code;
  logic       run_end;
  logic       oid_end;

  modport source (output valid, text_char, error_code, run_end, oid_end, input ready);
  modport sink   (input valid, text_char, error_code, run_end, oid_end, output ready);
endinterface

@@ sv/oid_ber_to_dotted_text.sv @@
// ----------------------------------------------------------------------------
// oid_ber_to_dotted_text
// Decodes BER object identifier content octets into dotted-decimal ASCII.
// ----------------------------------------------------------------------------
// byte_in takes one content octet per request with final_byte marking the
// last octet of the identifier. text_out gives one character per request,
// with run_end on the last character caused by an octet and oid_end on the
// last character of the identifier. An error gives a single request with
// text_char zero and error_code set.
// A continuation octet gives nothing. A terminating octet prints each arc
// through the shared bit-serial BCD converter: a conversion, then one
// decimal position at a time (20 at 64 bits, leading zeros skipped but
// for the last), with a dot before each later arc; a split first
// subidentifier prints two arcs. byte_in is ready only while the
// sequencer is idle.
// The last character sits in an output register, so a new octet is taken
// while it waits; a stalled receiver holds the sequencer before its next
// character. Reset clears the accumulator and status and sets absolute_oid
// to one; no clearing pass is needed.
// ----------------------------------------------------------------------------
module oid_ber_to_dotted_text #(
  parameter int ACC_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  obd_byte_if.sink                          byte_in,
  obd_text_if.source                        text_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [obd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [obd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [obd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int NUM_DIGITS = (ACC_WIDTH * 30103) / 100000 + 1;
  localparam int DCNT_W     = $clog2(NUM_DIGITS);
  localparam logic [ACC_WIDTH-1:0] TOP7  = ~({ACC_WIDTH{1'b1}} >> 7);
  localparam logic [ACC_WIDTH-1:0] SPLIT = ACC_WIDTH'(obd_pkg::ARC_SPLIT);
  localparam logic [ACC_WIDTH-1:0] RADIX = ACC_WIDTH'(obd_pkg::ARC_RADIX);
  localparam logic [ACC_WIDTH-1:0] ARC_0 = ACC_WIDTH'(0);
  localparam logic [ACC_WIDTH-1:0] ARC_1 = ACC_WIDTH'(1);
  localparam logic [ACC_WIDTH-1:0] ARC_2 = ACC_WIDTH'(2);

  obd_pkg::state_t    state, state_next;
  obd_pkg::cnv_ctl_t  cnv_ctl;
  obd_pkg::err_code_t err_code;

  logic                  absolute_oid;
  logic [ACC_WIDTH-1:0]  acc;
  logic                  seen;
  logic                  err_hold;
  logic [ACC_WIDTH-1:0]  conv_val;
  logic [ACC_WIDTH-1:0]  second_val;
  logic                  more;
  logic                  fin;
  logic [DCNT_W-1:0]     dcnt;
  logic                  lead;

  logic                  in_fire;
  logic                  overflow;
  logic                  cont;
  logic [ACC_WIDTH-1:0]  acc_shift;
  logic                  lt_split;
  logic                  ge_radix;
  logic                  split;
  logic [ACC_WIDTH-1:0]  first_val;
  logic [ACC_WIDTH-1:0]  arc2;
  logic [ACC_WIDTH-1:0]  cnv_value;
  logic                  cnv_done;
  logic [3:0]            digit;
  logic                  slot_free;
  logic                  skip;
  logic                  last_digit;

  logic                  emit;
  logic [7:0]            emit_char;
  logic [1:0]            emit_err;
  logic                  emit_run;
  logic                  emit_oid;

  obd_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .absolute_oid (absolute_oid)
  );

  obd_dabble #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cnv_ctl),
    .value     (cnv_value),
    .done      (cnv_done),
    .top_digit (digit)
  );

  assign byte_in.ready = (state == obd_pkg::ST_IDLE);
  assign in_fire       = byte_in.valid && byte_in.ready;
  assign overflow      = |(acc & TOP7);
  assign cont          = byte_in.content_byte[obd_pkg::CONT_BIT];
  assign acc_shift     = {acc[ACC_WIDTH-8:0], byte_in.content_byte[6:0]};
  assign lt_split      = (acc_shift < SPLIT);
  assign ge_radix      = (acc_shift >= RADIX);
  assign split         = absolute_oid && !seen;
  assign first_val     = split ? (lt_split ? (ge_radix ? ARC_1 : ARC_0) : ARC_2) : acc_shift;
  assign arc2          = lt_split ? (ge_radix ? acc_shift - RADIX : acc_shift)
                                  : acc_shift - SPLIT;
  assign cnv_value     = (state == obd_pkg::ST_IDLE) ? first_val : conv_val;
  assign slot_free     = !text_out.valid || text_out.ready;
  assign skip          = (digit == 4'd0) && !lead && (dcnt != '0);
  assign last_digit    = (dcnt == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      obd_pkg::ST_IDLE: begin
        if (in_fire && !err_hold) begin
          if (overflow) begin
            state_next = obd_pkg::ST_ERR;
          end else if (cont) begin
            state_next = byte_in.final_byte ? obd_pkg::ST_ERR : obd_pkg::ST_IDLE;
          end else if (split || !seen) begin
            state_next = obd_pkg::ST_CONV;
          end else begin
            state_next = obd_pkg::ST_DOT;
          end
        end
      end
      obd_pkg::ST_ERR: begin
        if (slot_free) state_next = obd_pkg::ST_IDLE;
      end
      obd_pkg::ST_DOT: begin
        if (slot_free) state_next = obd_pkg::ST_CONV;
      end
      obd_pkg::ST_CONV: begin
        if (cnv_done) state_next = obd_pkg::ST_EMIT;
      end
      obd_pkg::ST_EMIT: begin
        if (!skip && slot_free && last_digit) begin
          state_next = more ? obd_pkg::ST_DOT : obd_pkg::ST_IDLE;
        end
      end
      default: state_next = obd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    emit          = 1'b0;
    emit_char     = obd_pkg::CHAR_NONE;
    emit_err      = obd_pkg::ERR_NONE;
    emit_run      = 1'b0;
    emit_oid      = 1'b0;
    cnv_ctl.start = (state_next == obd_pkg::ST_CONV) && (state != obd_pkg::ST_CONV);
    cnv_ctl.shift = 1'b0;
    unique case (state)
      obd_pkg::ST_IDLE: begin
      end
      obd_pkg::ST_ERR: begin
        emit     = slot_free;
        emit_err = err_code;
        emit_run = 1'b1;
        emit_oid = fin;
      end
      obd_pkg::ST_DOT: begin
        emit      = slot_free;
        emit_char = obd_pkg::CHAR_DOT;
      end
      obd_pkg::ST_CONV: begin
      end
      obd_pkg::ST_EMIT: begin
        emit          = !skip && slot_free;
        emit_char     = obd_pkg::CHAR_ZERO | {4'd0, digit};
        emit_run      = last_digit && !more;
        emit_oid      = last_digit && !more && fin;
        cnv_ctl.shift = skip || slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= obd_pkg::ST_IDLE;
      acc      <= '0;
      seen     <= 1'b0;
      err_hold <= 1'b0;
      more     <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        if (err_hold) begin
          if (byte_in.final_byte) begin
            acc      <= '0;
            seen     <= 1'b0;
            err_hold <= 1'b0;
          end
        end else if (overflow) begin
          if (byte_in.final_byte) begin
            acc  <= '0;
            seen <= 1'b0;
          end else begin
            err_hold <= 1'b1;
          end
        end else if (cont) begin
          if (byte_in.final_byte) begin
            acc  <= '0;
            seen <= 1'b0;
          end else begin
            acc <= acc_shift;
          end
        end else begin
          acc  <= '0;
          seen <= !byte_in.final_byte;
          more <= split;
        end
      end else if (state == obd_pkg::ST_EMIT && !skip && slot_free && last_digit) begin
        more <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fin        <= byte_in.final_byte;
      conv_val   <= first_val;
      second_val <= arc2;
      err_code   <= overflow ? obd_pkg::ERR_OVERFLOW : obd_pkg::ERR_TRUNCATED;
    end else if (state == obd_pkg::ST_EMIT && !skip && slot_free && last_digit) begin
      conv_val <= second_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cnv_done) begin
      dcnt <= DCNT_W'(NUM_DIGITS - 1);
      lead <= 1'b0;
    end else if (cnv_ctl.shift) begin
      dcnt <= dcnt - DCNT_W'(1);
      if (!skip) lead <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_out.valid <= 1'b0;
    end else if (emit) begin
      text_out.valid <= 1'b1;
    end else if (text_out.ready) begin
      text_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      text_out.text_char  <= emit_char;
      text_out.error_code <= emit_err;
      text_out.run_end    <= emit_run;
      text_out.oid_end    <= emit_oid;
    end
  end

endmodule

@@ sv/obd_regs.sv @@
// ----------------------------------------------------------------------------
// obd_regs
// APB-style configuration register file, holds the absolute_oid mode bit.
// ----------------------------------------------------------------------------
module obd_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [obd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [obd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [obd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic                              absolute_oid
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == obd_pkg::REG_ABSOLUTE_OID);

  always_ff @(posedge clk) begin
    if (rst) begin
      absolute_oid <= 1'b1;
    end else if (psel && penable && pwrite && pready && hit) begin
      absolute_oid <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[0] = absolute_oid;
    end
  end

endmodule

@@ sv/obd_dabble.sv @@
// ----------------------------------------------------------------------------
// obd_dabble
// Shift-and-add-3 binary to BCD converter, one bit per cycle, with a digit
// shift-out port for serial printing.
// ----------------------------------------------------------------------------
module obd_dabble #(
  parameter int ACC_WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  obd_pkg::cnv_ctl_t        ctl,
  input  logic [ACC_WIDTH-1:0]     value,
  output logic                     done,
  output logic [3:0]               top_digit
);

  localparam int NUM_DIGITS = (ACC_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(ACC_WIDTH + 1);

  logic [ACC_WIDTH-1:0] bin;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign done      = busy && (cnt == CNT_W'(ACC_WIDTH));
  assign top_digit = bcd[BCD_W-1 -: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy && !done) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[ACC_WIDTH-1]};
      bin <= {bin[ACC_WIDTH-2:0], 1'b0};
    end else if (ctl.shift) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
    end
  end

endmodule
